FILE: sv/brb_pkg.sv
package brb_pkg;

    localparam int OP_W   = 3;
    localparam int DATA_W = 8;
    localparam int AMT_W  = 10;
    localparam int CNT_W  = 10;
    localparam int RUN_W  = 11;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_PEEK    = 3'd2,
        OP_ADV_RD  = 3'd3,
        OP_ADV_WR  = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_ROOM = 2'd1,
        STAT_NO_DATA = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic respond;
    } ctrl_cmd_t;

endpackage

FILE: sv/byte_ring_buffer.sv
// Byte ring buffer of BUFFER_DEPTH slots that holds at most BUFFER_DEPTH-1 bytes. An operation
// is taken when start is high and busy is low; its result is on the outputs with done high for
// the one cycle that begins two cycles after that edge, and it cannot be held off, so the
// receiver must take it then. A new operation is not taken until busy falls again after the
// load, execute and respond steps of the controller; the byte memory has a registered read, so
// a popped or peeked byte is ready only in the respond step. Refused operations leave the
// buffer unchanged and report it in status.
module byte_ring_buffer #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [brb_pkg::OP_W-1:0]   op,
    input  logic [brb_pkg::DATA_W-1:0] data_in,
    input  logic [brb_pkg::AMT_W-1:0]  amount,
    output logic                       done,
    output logic [brb_pkg::DATA_W-1:0] data_out,
    output logic [brb_pkg::CNT_W-1:0]  used_bytes,
    output logic [brb_pkg::CNT_W-1:0]  free_bytes,
    output logic [brb_pkg::RUN_W-1:0]  direct_enqueue,
    output logic [brb_pkg::RUN_W-1:0]  direct_dequeue,
    output logic [brb_pkg::STAT_W-1:0] status
);

    brb_pkg::ctrl_cmd_t cmd;

    brb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    brb_datapath #(
        .DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .op             (op),
        .data_in        (data_in),
        .amount         (amount),
        .done           (done),
        .data_out       (data_out),
        .used_bytes     (used_bytes),
        .free_bytes     (free_bytes),
        .direct_enqueue (direct_enqueue),
        .direct_dequeue (direct_dequeue),
        .status         (status)
    );

endmodule

FILE: sv/brb_ram.sv
module brb_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [brb_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [brb_pkg::DATA_W-1:0] rdata
);

    logic [brb_pkg::DATA_W-1:0] mem [DEPTH];
    logic [brb_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/brb_datapath.sv
module brb_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  brb_pkg::ctrl_cmd_t         cmd,
    input  logic [brb_pkg::OP_W-1:0]   op,
    input  logic [brb_pkg::DATA_W-1:0] data_in,
    input  logic [brb_pkg::AMT_W-1:0]  amount,
    output logic                       done,
    output logic [brb_pkg::DATA_W-1:0] data_out,
    output logic [brb_pkg::CNT_W-1:0]  used_bytes,
    output logic [brb_pkg::CNT_W-1:0]  free_bytes,
    output logic [brb_pkg::RUN_W-1:0]  direct_enqueue,
    output logic [brb_pkg::RUN_W-1:0]  direct_dequeue,
    output logic [brb_pkg::STAT_W-1:0] status
);

    localparam int AW = $clog2(DEPTH);
    localparam int XW = ((AW > brb_pkg::AMT_W) ? AW : brb_pkg::AMT_W) + 1;
    localparam logic [XW:0]   DEPTH_S = (XW+1)'(DEPTH);
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    logic [brb_pkg::OP_W-1:0]   op_reg;
    logic [brb_pkg::DATA_W-1:0] din_reg;
    logic [brb_pkg::AMT_W-1:0]  amt_reg;

    logic [AW-1:0] rd_reg, rd_next;
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    brb_pkg::status_t stat_reg, stat_next;
    logic rdv_reg, rdv_next;

    logic                       done_reg;
    logic [brb_pkg::DATA_W-1:0] dout_reg;
    logic [brb_pkg::CNT_W-1:0]  used_out_reg;
    logic [brb_pkg::CNT_W-1:0]  free_out_reg;
    logic [brb_pkg::RUN_W-1:0]  denq_out_reg;
    logic [brb_pkg::RUN_W-1:0]  ddeq_out_reg;
    brb_pkg::status_t           stat_out_reg;

    logic [XW-1:0] cnt_x, free_x, amt_x;
    logic [AW-1:0] rd_plus_1, rd_plus_amt, wr_plus_1, wr_plus_amt;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_raddr;
    logic [brb_pkg::DATA_W-1:0] mem_q;
    logic [XW-1:0] denq, ddeq;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] idx,
                                               input logic [XW-1:0] n);
        logic [XW:0] s;
        begin
            s = (XW+1)'(idx) + (XW+1)'(n);
            if (s >= DEPTH_S)
            begin
                s = s - DEPTH_S;
            end
            return s[AW-1:0];
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            din_reg <= data_in;
            amt_reg <= amount;
        end
    end

    assign cnt_x  = XW'(cnt_reg);
    assign free_x = DEPTH_X - XW'(1) - cnt_x;
    assign amt_x  = XW'(amt_reg);

    assign rd_plus_1   = wrap_add(rd_reg, XW'(1));
    assign rd_plus_amt = wrap_add(rd_reg, amt_x);
    assign wr_plus_1   = wrap_add(wr_reg, XW'(1));
    assign wr_plus_amt = wrap_add(wr_reg, amt_x);

    always_comb
    begin
        rd_next   = rd_reg;
        wr_next   = wr_reg;
        cnt_next  = cnt_reg;
        stat_next = brb_pkg::STAT_OK;
        rdv_next  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = rd_reg;
        case (op_reg)
            brb_pkg::OP_PUSH:
            begin
                if (cnt_x == DEPTH_X - XW'(1))
                begin
                    stat_next = brb_pkg::STAT_NO_ROOM;
                end
                else
                begin
                    mem_we   = 1'b1;
                    wr_next  = wr_plus_1;
                    cnt_next = AW'(cnt_x + XW'(1));
                end
            end
            brb_pkg::OP_POP:
            begin
                if (cnt_x == '0)
                begin
                    stat_next = brb_pkg::STAT_NO_DATA;
                end
                else
                begin
                    mem_re   = 1'b1;
                    rdv_next = 1'b1;
                    rd_next  = rd_plus_1;
                    cnt_next = AW'(cnt_x - XW'(1));
                end
            end
            brb_pkg::OP_PEEK:
            begin
                mem_raddr = rd_plus_amt;
                if (amt_x >= cnt_x)
                begin
                    stat_next = brb_pkg::STAT_NO_DATA;
                end
                else
                begin
                    mem_re   = 1'b1;
                    rdv_next = 1'b1;
                end
            end
            brb_pkg::OP_ADV_RD:
            begin
                if (amt_x > cnt_x)
                begin
                    stat_next = brb_pkg::STAT_NO_DATA;
                end
                else
                begin
                    rd_next  = rd_plus_amt;
                    cnt_next = AW'(cnt_x - amt_x);
                end
            end
            brb_pkg::OP_ADV_WR:
            begin
                if (amt_x > free_x)
                begin
                    stat_next = brb_pkg::STAT_NO_ROOM;
                end
                else
                begin
                    wr_next  = wr_plus_amt;
                    cnt_next = AW'(cnt_x + amt_x);
                end
            end
            brb_pkg::OP_CLEAR:
            begin
                wr_next  = rd_reg;
                cnt_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.exec)
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            stat_reg <= stat_next;
            rdv_reg  <= rdv_next;
        end
    end

    brb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.exec && mem_we),
        .waddr (wr_reg),
        .wdata (din_reg),
        .re    (cmd.exec && mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    always_comb
    begin
        if (wr_reg < rd_reg)
        begin
            denq = XW'(rd_reg) - XW'(wr_reg) - XW'(1);
            ddeq = DEPTH_X - XW'(rd_reg);
        end
        else
        begin
            denq = DEPTH_X - XW'(wr_reg) - ((rd_reg == '0) ? XW'(1) : XW'(0));
            ddeq = XW'(wr_reg) - XW'(rd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            dout_reg     <= rdv_reg ? mem_q : '0;
            used_out_reg <= brb_pkg::CNT_W'(cnt_reg);
            free_out_reg <= brb_pkg::CNT_W'(DEPTH_X - XW'(1) - XW'(cnt_reg));
            denq_out_reg <= brb_pkg::RUN_W'(denq);
            ddeq_out_reg <= brb_pkg::RUN_W'(ddeq);
            stat_out_reg <= stat_reg;
        end
    end

    assign done           = done_reg;
    assign data_out       = dout_reg;
    assign used_bytes     = used_out_reg;
    assign free_bytes     = free_out_reg;
    assign direct_enqueue = denq_out_reg;
    assign direct_dequeue = ddeq_out_reg;
    assign status         = stat_out_reg;

endmodule

FILE: sv/brb_ctrl.sv
module brb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output brb_pkg::ctrl_cmd_t cmd
);

    brb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.respond = 1'b0;
        busy        = 1'b1;
        case (state_reg)
            brb_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = brb_pkg::S_EXEC;
                end
            end
            brb_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = brb_pkg::S_RESP;
            end
            brb_pkg::S_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = brb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = brb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/tb_byte_ring_buffer.sv
module tb_byte_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH   = 1024;
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_TAIL   = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    localparam logic [brb_pkg::OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [brb_pkg::OP_W-1:0] OP_RSVD_HI = 3'd7;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    typedef struct {
        logic [brb_pkg::DATA_W-1:0] data;
        logic [brb_pkg::CNT_W-1:0]  used_cnt;
        logic [brb_pkg::CNT_W-1:0]  free_cnt;
        logic [brb_pkg::RUN_W-1:0]  enq_run;
        logic [brb_pkg::RUN_W-1:0]  deq_run;
        logic [brb_pkg::STAT_W-1:0] status;
    } ring_result_t;

    class ring_scoreboard;
        logic [brb_pkg::DATA_W-1:0] slot [RING_DEPTH];
        bit                         slot_written [RING_DEPTH];
        int                         rd_ptr;
        int                         wr_ptr;
        ring_result_t               expected_q [$];
        int                         failures;
        int                         results_checked;
        int                         refusals;
        int                         peak_fill;
        int                         op_seen [8];

        function new();
            rd_ptr          = 0;
            wr_ptr          = 0;
            failures        = 0;
            results_checked = 0;
            refusals        = 0;
            peak_fill       = 0;
            foreach (slot_written[i])
            begin
                slot_written[i] = 1'b0;
                slot[i]         = '0;
            end
            foreach (op_seen[i])
            begin
                op_seen[i] = 0;
            end
        endfunction

        function int fill();
            if (wr_ptr >= rd_ptr)
            begin
                return wr_ptr - rd_ptr;
            end
            return wr_ptr + RING_DEPTH - rd_ptr;
        endfunction

        function int room();
            return RING_DEPTH - 1 - fill();
        endfunction

        function bit readable(int offset);
            return slot_written[(rd_ptr + offset) % RING_DEPTH];
        endfunction

        function void note_input(logic [brb_pkg::OP_W-1:0] code,
                                 logic [brb_pkg::DATA_W-1:0] din,
                                 logic [brb_pkg::AMT_W-1:0] amt);
            ring_result_t want;
            int           used_now;
            int           free_now;
            int           count;
            int           enq;
            int           deq;

            used_now    = fill();
            free_now    = room();
            count       = int'(amt);
            want.data   = '0;
            want.status = brb_pkg::STAT_OK;
            op_seen[code]++;

            case (code)
                brb_pkg::OP_PUSH:
                begin
                    if (free_now == 0)
                    begin
                        want.status = brb_pkg::STAT_NO_ROOM;
                    end
                    else
                    begin
                        slot[wr_ptr]         = din;
                        slot_written[wr_ptr] = 1'b1;
                        wr_ptr               = (wr_ptr + 1) % RING_DEPTH;
                    end
                end
                brb_pkg::OP_POP:
                begin
                    if (used_now == 0)
                    begin
                        want.status = brb_pkg::STAT_NO_DATA;
                    end
                    else
                    begin
                        want.data = slot[rd_ptr];
                        rd_ptr    = (rd_ptr + 1) % RING_DEPTH;
                    end
                end
                brb_pkg::OP_PEEK:
                begin
                    if (count >= used_now)
                    begin
                        want.status = brb_pkg::STAT_NO_DATA;
                    end
                    else
                    begin
                        want.data = slot[(rd_ptr + count) % RING_DEPTH];
                    end
                end
                brb_pkg::OP_ADV_RD:
                begin
                    if (count > used_now)
                    begin
                        want.status = brb_pkg::STAT_NO_DATA;
                    end
                    else
                    begin
                        rd_ptr = (rd_ptr + count) % RING_DEPTH;
                    end
                end
                brb_pkg::OP_ADV_WR:
                begin
                    if (count > free_now)
                    begin
                        want.status = brb_pkg::STAT_NO_ROOM;
                    end
                    else
                    begin
                        wr_ptr = (wr_ptr + count) % RING_DEPTH;
                    end
                end
                brb_pkg::OP_CLEAR:
                begin
                    wr_ptr = rd_ptr;
                end
                default:
                begin
                end
            endcase

            if (wr_ptr < rd_ptr)
            begin
                enq = rd_ptr - wr_ptr - 1;
                deq = RING_DEPTH - rd_ptr;
            end
            else
            begin
                enq = RING_DEPTH - wr_ptr - ((rd_ptr == 0) ? 1 : 0);
                deq = wr_ptr - rd_ptr;
            end

            want.used_cnt = brb_pkg::CNT_W'(fill());
            want.free_cnt = brb_pkg::CNT_W'(room());
            want.enq_run  = brb_pkg::RUN_W'(enq);
            want.deq_run  = brb_pkg::RUN_W'(deq);
            if (want.status != brb_pkg::STAT_OK)
            begin
                refusals++;
            end
            if (fill() > peak_fill)
            begin
                peak_fill = fill();
            end
            expected_q.push_back(want);
        endfunction

        function void check_result(ring_result_t got);
            ring_result_t want;

            results_checked++;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("[%0t] result with no operation outstanding: data %02h status %0d",
                             $realtime, got.data, got.status);
                end
                return;
            end
            want = expected_q.pop_front();
            if (got.data !== want.data || got.used_cnt !== want.used_cnt ||
                got.free_cnt !== want.free_cnt || got.enq_run !== want.enq_run ||
                got.deq_run !== want.deq_run || got.status !== want.status)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display({"[%0t] mismatch: expected data %02h used %0d free %0d",
                              " enq %0d deq %0d st %0d"},
                             $realtime, want.data, want.used_cnt, want.free_cnt,
                             want.enq_run, want.deq_run, want.status);
                    $display({"             actual   data %02h used %0d free %0d",
                              " enq %0d deq %0d st %0d"},
                             got.data, got.used_cnt, got.free_cnt,
                             got.enq_run, got.deq_run, got.status);
                end
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [brb_pkg::OP_W-1:0]   op = '0;
    logic [brb_pkg::DATA_W-1:0] data_in = '0;
    logic [brb_pkg::AMT_W-1:0]  amount = '0;
    logic                       done;
    logic [brb_pkg::DATA_W-1:0] data_out;
    logic [brb_pkg::CNT_W-1:0]  used_bytes;
    logic [brb_pkg::CNT_W-1:0]  free_bytes;
    logic [brb_pkg::RUN_W-1:0]  direct_enqueue;
    logic [brb_pkg::RUN_W-1:0]  direct_dequeue;
    logic [brb_pkg::STAT_W-1:0] status;

    ring_scoreboard sb;

    byte_ring_buffer #(
        .BUFFER_DEPTH(RING_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .data_in       (data_in),
        .amount        (amount),
        .done          (done),
        .data_out      (data_out),
        .used_bytes    (used_bytes),
        .free_bytes    (free_bytes),
        .direct_enqueue(direct_enqueue),
        .direct_dequeue(direct_dequeue),
        .status        (status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin : result_monitor
        ring_result_t seen;
        if (rst_n && done)
        begin
            seen.data     = data_out;
            seen.used_cnt = used_bytes;
            seen.free_cnt = free_bytes;
            seen.enq_run  = direct_enqueue;
            seen.deq_run  = direct_dequeue;
            seen.status   = status;
            sb.check_result(seen);
        end
    end

    // The transfer completes at the first edge that sees start high and busy low.
    task automatic issue(input logic [brb_pkg::OP_W-1:0] code,
                         input logic [brb_pkg::DATA_W-1:0] din,
                         input logic [brb_pkg::AMT_W-1:0] amt);
        start   <= 1'b1;
        op      <= code;
        data_in <= din;
        amount  <= amt;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        sb.note_input(code, din, amt);
    endtask

    task automatic pause(input int cycles);
        start   <= 1'b0;
        op      <= brb_pkg::OP_W'($urandom);
        data_in <= brb_pkg::DATA_W'($urandom);
        amount  <= brb_pkg::AMT_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic pick_item(input traffic_mode_t mode,
                             output logic [brb_pkg::OP_W-1:0] code,
                             output logic [brb_pkg::DATA_W-1:0] din,
                             output logic [brb_pkg::AMT_W-1:0] amt);
        int w [6];
        int roll;
        int pick;
        int used_now;
        int free_now;
        int limit;

        case (mode)
            MODE_FILL:  w = '{50, 12, 14, 6, 14, 1};
            MODE_DRAIN: w = '{15, 40, 14, 18, 6, 4};
            default:    w = '{30, 28, 18, 10, 10, 1};
        endcase
        roll     = $urandom_range(0, 99);
        used_now = sb.fill();
        free_now = sb.room();
        din      = brb_pkg::DATA_W'($urandom);
        amt      = brb_pkg::AMT_W'($urandom);

        if (roll < w[0])
            code = brb_pkg::OP_PUSH;
        else if (roll < w[0] + w[1])
            code = brb_pkg::OP_POP;
        else if (roll < w[0] + w[1] + w[2])
            code = brb_pkg::OP_PEEK;
        else if (roll < w[0] + w[1] + w[2] + w[3])
            code = brb_pkg::OP_ADV_RD;
        else if (roll < w[0] + w[1] + w[2] + w[3] + w[4])
            code = brb_pkg::OP_ADV_WR;
        else if (roll < w[0] + w[1] + w[2] + w[3] + w[4] + w[5])
            code = brb_pkg::OP_CLEAR;
        else
            code = ($urandom_range(0, 1) != 0) ? OP_RSVD_HI : OP_RSVD_LO;

        // Reads never land on a slot that has not been written yet.
        case (code)
            brb_pkg::OP_POP:
            begin
                if (used_now > 0 && !sb.readable(0))
                begin
                    code = brb_pkg::OP_ADV_RD;
                    amt  = brb_pkg::AMT_W'(1);
                end
            end
            brb_pkg::OP_PEEK:
            begin
                if (used_now > 0 && $urandom_range(0, 3) != 0)
                begin
                    amt = brb_pkg::AMT_W'($urandom_range(0, used_now - 1));
                end
                if (amt < used_now && !sb.readable(int'(amt)))
                begin
                    amt = brb_pkg::AMT_W'(used_now);
                end
            end
            brb_pkg::OP_ADV_RD, brb_pkg::OP_ADV_WR:
            begin
                limit = (code == brb_pkg::OP_ADV_RD) ? used_now : free_now;
                pick  = $urandom_range(0, 9);
                if (pick < 5)
                    amt = brb_pkg::AMT_W'($urandom_range(0, (limit < 16) ? limit : 16));
                else if (pick < 7)
                    amt = brb_pkg::AMT_W'($urandom_range(0, limit));
                else if (pick < 8 && limit < RING_DEPTH - 1)
                    amt = brb_pkg::AMT_W'(limit + 1);
            end
            default:
            begin
            end
        endcase
    endtask

    initial
    begin
        #4_000_000;
        $display("** byte_ring_buffer: FAILED **");
        $finish;
    end

    initial
    begin
        logic [brb_pkg::OP_W-1:0]   code;
        logic [brb_pkg::DATA_W-1:0] din;
        logic [brb_pkg::AMT_W-1:0]  amt;
        traffic_mode_t              mode;
        int                         n_items;
        int                         block_left;
        int                         gap_pct;
        int                         leftover;

        sb         = new();
        n_items    = 0;
        block_left = 0;
        gap_pct    = 0;
        mode       = MODE_MIXED;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(brb_pkg::OP_POP, 8'h00, 10'd0);
        issue(brb_pkg::OP_PEEK, 8'h00, 10'd0);
        issue(brb_pkg::OP_ADV_RD, 8'h00, 10'd1);
        issue(brb_pkg::OP_ADV_RD, 8'h00, 10'd0);
        issue(brb_pkg::OP_ADV_WR, 8'h00, 10'd0);
        issue(brb_pkg::OP_PUSH, 8'h00, 10'd0);
        issue(brb_pkg::OP_PUSH, 8'hFF, 10'd0);
        issue(brb_pkg::OP_PUSH, 8'h5A, 10'd0);
        issue(brb_pkg::OP_PEEK, 8'h00, 10'd0);
        issue(brb_pkg::OP_PEEK, 8'h00, 10'd2);
        issue(brb_pkg::OP_PEEK, 8'h00, 10'd3);
        issue(brb_pkg::OP_POP, 8'h00, 10'd0);
        issue(brb_pkg::OP_ADV_RD, 8'h00, 10'd1);
        issue(brb_pkg::OP_POP, 8'h00, 10'd0);
        issue(brb_pkg::OP_ADV_WR, 8'h00, 10'd1023);
        issue(brb_pkg::OP_PUSH, 8'hC3, 10'd0);
        issue(brb_pkg::OP_ADV_WR, 8'h00, 10'd1);
        issue(brb_pkg::OP_PEEK, 8'h00, 10'd1023);
        issue(brb_pkg::OP_ADV_RD, 8'h00, 10'd1023);
        issue(brb_pkg::OP_PUSH, 8'h81, 10'd0);
        issue(brb_pkg::OP_CLEAR, 8'h00, 10'd0);
        issue(OP_RSVD_LO, 8'hFF, 10'd1023);
        issue(OP_RSVD_HI, 8'h00, 10'd0);
        issue(brb_pkg::OP_PUSH, 8'h7E, 10'd0);
        issue(brb_pkg::OP_ADV_RD, 8'h00, 10'd1);

        while (n_items < RANDOM_ITEMS)
        begin
            if (block_left == 0)
            begin
                mode       = traffic_mode_t'($urandom_range(0, 2));
                block_left = $urandom_range(40, 140);
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 20;
                    default: gap_pct = 50;
                endcase
            end
            block_left--;
            if (n_items < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < gap_pct)
            begin
                pause($urandom_range(1, 6));
            end
            pick_item(mode, code, din, amt);
            issue(code, din, amt);
            if (code != OP_RSVD_LO && code != OP_RSVD_HI)
            begin
                n_items++;
            end
        end

        start <= 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        leftover = sb.expected_q.size();
        if (leftover != 0)
        begin
            $display("%0d operations never produced a result", leftover);
        end
        $display({"Operations: push %0d, pop %0d, peek %0d, skip-read %0d,",
                  " skip-write %0d, clear %0d, reserved %0d"},
                 sb.op_seen[brb_pkg::OP_PUSH], sb.op_seen[brb_pkg::OP_POP],
                 sb.op_seen[brb_pkg::OP_PEEK], sb.op_seen[brb_pkg::OP_ADV_RD],
                 sb.op_seen[brb_pkg::OP_ADV_WR], sb.op_seen[brb_pkg::OP_CLEAR],
                 sb.op_seen[OP_RSVD_LO] + sb.op_seen[OP_RSVD_HI]);
        $display("Checked %0d results, %0d refused, peak fill %0d of %0d, %0d mismatches",
                 sb.results_checked, sb.refusals, sb.peak_fill, RING_DEPTH - 1, sb.failures);
        if (sb.failures == 0 && leftover == 0)
        begin
            $display("** byte_ring_buffer: PASSED **");
        end
        else
        begin
            $display("** byte_ring_buffer: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/brb_pkg.sv
sv/brb_ram.sv
sv/brb_datapath.sv
sv/brb_ctrl.sv
sv/byte_ring_buffer.sv
tb/tb_byte_ring_buffer.sv
